[sv/sts_pkg.sv]
// Shared types and constants for the sorted table search block.
// Used by the controller, the datapath and the top level; depends on nothing.
package sts_pkg;

  localparam int DATA_W  = 32;
  localparam int INDEX_W = 10;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BINARY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INTERP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EXPO   = 2'd3;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Read address sources.
  typedef enum logic [2:0] {
    ASEL_LO, ASEL_HI, ASEL_MID, ASEL_BND, ASEL_ZERO, ASEL_INTERP
  } asel_t;

  typedef enum logic [1:0] {
    LO_KEEP, LO_POS_INC, LO_BND_HALF
  } lo_op_t;

  typedef enum logic [1:0] {
    HI_KEEP, HI_POS_DEC, HI_BND_TOP
  } hi_op_t;

  typedef struct packed {
    logic   load;
    logic   rd;
    asel_t  asel;
    lo_op_t lo_op;
    hi_op_t hi_op;
    logic   bnd_dbl;
    logic   cap_alo;
    logic   cap_diff;
    logic   mul;
    logic   div_start;
    logic   res_set;
    logic   res_found;
    logic   res_lo;
    logic   push;
  } cmd_t;

  typedef struct packed {
    logic              act_search;
    logic [MODE_W-1:0] mode;
    logic              n_zero;
    logic              lo_le_hi;
    logic              lo_eq_hi;
    logic              bnd_lt_n;
    logic              rd_eq;
    logic              rd_gt;
    logic              rd_lt;
    logic              rd_eq_alo;
    logic              alo_eq_key;
    logic              div_done;
    logic              out_free;
  } sts_t;

endpackage

[sv/sorted_table_search_top.sv]
// Top level of the sorted table search: joins the controller and the datapath.
// Depends on sts_pkg, sts_ctrl, sts_dp and sts_div.
//
//   Channel  Direction  Handshake          Beat carries
//   in_      input      in_valid/in_stall  action, index, value
//   out_     output     out_valid/out_stall found, position
//   cfg_     input      cfg_valid/cfg_ready register index, data
//
// A write beat passes through the dispatch state and returns to idle. Search
// time is set by the single table read port and, in interpolation mode, by
// the one-bit-per-cycle divider used for each probe. One item is in flight at
// a time; the result register lets the next item enter while a result is
// still stalled.
// Reset is synchronous and needs no clearing pass; configuration is always ready.
module sorted_table_search_top #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [sts_pkg::INDEX_W-1:0]       in_index,
  input  logic signed [sts_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [sts_pkg::POS_W-1:0]         out_position,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sts_pkg::COUNT_W-1:0]       cfg_data
);
  import sts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sts_dp #(.DEPTH(DEPTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_index     (in_index),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_position (out_position),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

[sv/sts_div.sv]
// Restoring divider, one quotient bit per cycle, for the interpolation probe.
// The quotient is known to fit in QW bits. Depends on nothing.
module sts_div #(
  parameter int NW = 42,
  parameter int DW = 32,
  parameter int QW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [QW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    trial = {rem_r, q_r[QW-1]};
    diff  = trial - {1'b0, den_r};
    q_nxt = QW'({q_r, ~diff[DW]});
    if (diff[DW]) begin
      rem_nxt = trial[DW-1:0];
    end else begin
      rem_nxt = diff[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(QW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // The top part of the numerator is already below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DW'(num >> QW);
      q_r   <= num[QW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[sv/sts_dp.sv]
// Datapath: configuration registers, table memory, search bounds, multiplier,
// divider and output register. Uses sts_pkg and sts_div.
module sts_dp #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sts_pkg::cmd_t                 cmd,
  output sts_pkg::sts_t                 sts,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_action,
  input  logic [sts_pkg::INDEX_W-1:0]   in_index,
  input  logic signed [sts_pkg::DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [sts_pkg::POS_W-1:0]     out_position,
  input  logic                          cfg_valid,
  input  logic [sts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sts_pkg::COUNT_W-1:0]   cfg_data
);
  import sts_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = AW + 2;
  localparam int NW = DATA_W + AW;

  logic [MODE_W-1:0]  mode_r;
  logic [COUNT_W-1:0] count_r;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] alo_r;
  logic        [DATA_W-1:0] diff_r, den_r;
  logic        [AW-1:0]     span_r;
  logic        [NW-1:0]     prod_r;
  logic signed [IW-1:0]     lo_r, hi_r, bnd_r, n_r, pos_r;
  logic signed [IW-1:0]     sel_v, mid_v, n_v, nm1_v;
  logic        [AW-1:0]     quot;
  logic                     div_done;
  logic                     act_r;
  logic                     res_found_r;
  logic [POS_W-1:0]         res_pos_r;
  logic                     out_valid_r;
  logic                     out_found_r;
  logic [POS_W-1:0]         out_pos_r;
  logic                     in_acc;
  logic signed [DATA_W:0]   alo_x;

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BINARY;
      count_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MODE) begin
        mode_r <= cfg_data[MODE_W-1:0];
      end else begin
        count_r <= cfg_data;
      end
    end
  end

  always_comb begin
    if (32'(count_r) > 32'(DEPTH)) begin
      n_v = IW'(DEPTH);
    end else begin
      n_v = IW'(count_r);
    end
    nm1_v = n_r - IW'(1);
    mid_v = lo_r + ((hi_r - lo_r) >>> 1);
    unique case (cmd.asel)
      ASEL_LO:     sel_v = lo_r;
      ASEL_HI:     sel_v = hi_r;
      ASEL_MID:    sel_v = mid_v;
      ASEL_BND:    sel_v = bnd_r;
      ASEL_ZERO:   sel_v = '0;
      ASEL_INTERP: sel_v = lo_r + IW'(quot);
      default:     sel_v = lo_r;
    endcase
  end

  // Table memory: one write port from the input, one registered read port.
  always_ff @(posedge clk) begin
    if (in_acc && in_action == ACT_WRITE && 32'(in_index) < 32'(DEPTH)) begin
      mem[AW'(in_index)] <= in_value;
    end
    if (cmd.rd) begin
      rdata_r <= mem[sel_v[AW-1:0]];
      pos_r   <= sel_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= in_value;
      act_r <= in_action;
    end
    if (cmd.load) begin
      n_r   <= n_v;
      lo_r  <= '0;
      hi_r  <= n_v - IW'(1);
      bnd_r <= IW'(1);
    end else begin
      unique case (cmd.lo_op)
        LO_POS_INC:  lo_r <= pos_r + IW'(1);
        LO_BND_HALF: lo_r <= bnd_r >>> 1;
        default:     lo_r <= lo_r;
      endcase
      unique case (cmd.hi_op)
        HI_POS_DEC: hi_r <= pos_r - IW'(1);
        HI_BND_TOP: hi_r <= (bnd_r < nm1_v) ? bnd_r : nm1_v;
        default:    hi_r <= hi_r;
      endcase
      if (cmd.bnd_dbl) begin
        bnd_r <= bnd_r <<< 1;
      end
    end
    if (cmd.cap_alo) begin
      alo_r <= rdata_r;
    end
    if (cmd.cap_diff) begin
      diff_r <= DATA_W'(key_r - alo_r);
      den_r  <= DATA_W'(rdata_r - alo_r);
      span_r <= AW'(hi_r - lo_r);
    end
    if (cmd.mul) begin
      prod_r <= NW'(diff_r) * NW'(span_r);
    end
    if (cmd.res_set) begin
      res_found_r <= cmd.res_found;
      if (!cmd.res_found) begin
        res_pos_r <= '0;
      end else if (cmd.res_lo) begin
        res_pos_r <= POS_W'(lo_r);
      end else begin
        res_pos_r <= POS_W'(pos_r);
      end
    end
  end

  sts_div #(.NW(NW), .DW(DATA_W), .QW(AW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_found_r <= res_found_r;
      out_pos_r   <= res_pos_r;
    end
  end

  assign alo_x = {alo_r[DATA_W-1], alo_r};

  always_comb begin
    sts.act_search = act_r;
    sts.mode       = mode_r;
    sts.n_zero     = (n_r == '0);
    sts.lo_le_hi   = (lo_r <= hi_r);
    sts.lo_eq_hi   = (lo_r == hi_r);
    sts.bnd_lt_n   = (bnd_r < n_r);
    sts.rd_eq      = (rdata_r == key_r);
    sts.rd_gt      = (rdata_r > key_r);
    sts.rd_lt      = (rdata_r < key_r);
    sts.rd_eq_alo  = ({rdata_r[DATA_W-1], rdata_r} == alo_x);
    sts.alo_eq_key = (alo_r == key_r);
    sts.div_done   = div_done;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule

[sv/sts_ctrl.sv]
// Controller state machine: sequences table writes and the four search methods
// by issuing commands to the datapath. Uses sts_pkg.
module sts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sts_pkg::sts_t sts,
  output sts_pkg::cmd_t cmd
);
  import sts_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_LIN_RD   = 5'd2;
  localparam logic [4:0] S_LIN_CHK  = 5'd3;
  localparam logic [4:0] S_BIN_TEST = 5'd4;
  localparam logic [4:0] S_BIN_CHK  = 5'd5;
  localparam logic [4:0] S_EXP_RD0  = 5'd6;
  localparam logic [4:0] S_EXP_CHK0 = 5'd7;
  localparam logic [4:0] S_EXP_TEST = 5'd8;
  localparam logic [4:0] S_EXP_CHK  = 5'd9;
  localparam logic [4:0] S_EXP_RNG  = 5'd10;
  localparam logic [4:0] S_INT_TEST = 5'd11;
  localparam logic [4:0] S_INT_CLO  = 5'd12;
  localparam logic [4:0] S_INT_CHI  = 5'd13;
  localparam logic [4:0] S_INT_MUL  = 5'd14;
  localparam logic [4:0] S_INT_DST  = 5'd15;
  localparam logic [4:0] S_INT_DIV  = 5'd16;
  localparam logic [4:0] S_INT_CHK  = 5'd17;
  localparam logic [4:0] S_FIN      = 5'd18;

  logic [4:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.asel  = ASEL_LO;
    cmd.lo_op = LO_KEEP;
    cmd.hi_op = HI_KEEP;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.act_search != ACT_SEARCH) begin
          state_nxt = S_IDLE;
        end else if (sts.n_zero) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          unique case (sts.mode)
            MODE_LINEAR: state_nxt = S_LIN_RD;
            MODE_BINARY: state_nxt = S_BIN_TEST;
            MODE_INTERP: state_nxt = S_INT_TEST;
            default:     state_nxt = S_EXP_RD0;
          endcase
        end
      end
      S_LIN_RD: begin
        if (sts.lo_le_hi) begin
          cmd.rd    = 1'b1;
          cmd.asel  = ASEL_LO;
          state_nxt = S_LIN_CHK;
        end else begin
          cmd.res_set = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_LIN_CHK: begin
        if (sts.rd_eq) begin
          cmd.res_set   = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.lo_op = LO_POS_INC;
          state_nxt = S_LIN_RD;
        end
      end
      S_BIN_TEST: begin
        if (sts.lo_le_hi) begin
          cmd.rd    = 1'b1;
          cmd.asel  = ASEL_MID;
          state_nxt = S_BIN_CHK;
        end else begin
          cmd.res_set = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_BIN_CHK: begin
        if (sts.rd_eq) begin
          cmd.res_set   = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          if (sts.rd_gt) begin
            cmd.hi_op = HI_POS_DEC;
          end else begin
            cmd.lo_op = LO_POS_INC;
          end
          state_nxt = S_BIN_TEST;
        end
      end
      S_EXP_RD0: begin
        cmd.rd    = 1'b1;
        cmd.asel  = ASEL_ZERO;
        state_nxt = S_EXP_CHK0;
      end
      S_EXP_CHK0: begin
        if (sts.rd_eq) begin
          cmd.res_set   = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          state_nxt = S_EXP_TEST;
        end
      end
      S_EXP_TEST: begin
        if (sts.bnd_lt_n) begin
          cmd.rd    = 1'b1;
          cmd.asel  = ASEL_BND;
          state_nxt = S_EXP_CHK;
        end else begin
          state_nxt = S_EXP_RNG;
        end
      end
      S_EXP_CHK: begin
        if (!sts.rd_gt) begin
          cmd.bnd_dbl = 1'b1;
          state_nxt   = S_EXP_TEST;
        end else begin
          state_nxt = S_EXP_RNG;
        end
      end
      S_EXP_RNG: begin
        cmd.lo_op = LO_BND_HALF;
        cmd.hi_op = HI_BND_TOP;
        state_nxt = S_BIN_TEST;
      end
      S_INT_TEST: begin
        if (sts.lo_le_hi) begin
          cmd.rd    = 1'b1;
          cmd.asel  = ASEL_LO;
          state_nxt = S_INT_CLO;
        end else begin
          cmd.res_set = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_INT_CLO: begin
        cmd.cap_alo = 1'b1;
        if (sts.rd_gt) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd    = 1'b1;
          cmd.asel  = ASEL_HI;
          state_nxt = S_INT_CHI;
        end
      end
      S_INT_CHI: begin
        if (sts.rd_lt) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_FIN;
        end else if (sts.lo_eq_hi) begin
          cmd.res_set   = 1'b1;
          cmd.res_found = sts.alo_eq_key;
          cmd.res_lo    = 1'b1;
          state_nxt     = S_FIN;
        end else if (sts.rd_eq_alo) begin
          // Flat range: the key equals the low entry.
          cmd.res_set   = 1'b1;
          cmd.res_found = 1'b1;
          cmd.res_lo    = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.cap_diff = 1'b1;
          state_nxt    = S_INT_MUL;
        end
      end
      S_INT_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_INT_DST;
      end
      S_INT_DST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_INT_DIV;
      end
      S_INT_DIV: begin
        if (sts.div_done) begin
          cmd.rd    = 1'b1;
          cmd.asel  = ASEL_INTERP;
          state_nxt = S_INT_CHK;
        end
      end
      S_INT_CHK: begin
        if (sts.rd_eq) begin
          cmd.res_set   = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          if (sts.rd_lt) begin
            cmd.lo_op = LO_POS_INC;
          end else begin
            cmd.hi_op = HI_POS_DEC;
          end
          state_nxt = S_INT_TEST;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[tb/sv/sts_search_checker.sv]
// Checker for the sorted table search: watches the load, search, result and
// register channels, predicts each search result and compares it on arrival.
// Depends on sts_pkg only; it is instantiated beside the block by the test top.
module sts_search_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_action,
  input  logic [sts_pkg::INDEX_W-1:0]       in_index,
  input  logic signed [sts_pkg::DATA_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              out_found,
  input  logic [sts_pkg::POS_W-1:0]         out_position,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [sts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sts_pkg::COUNT_W-1:0]       cfg_data,
  output int                                fail_count,
  output int                                answers_waiting,
  output int                                searches_seen
);
  import sts_pkg::*;

  localparam int TBL_DEPTH = 1024;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } answer_t;

  logic signed [DATA_W-1:0] tbl [0:TBL_DEPTH-1];
  logic [MODE_W-1:0]        mode_q;
  logic [COUNT_W-1:0]       count_q;
  answer_t                  due_answers [$];

  assign answers_waiting = due_answers.size();

  function automatic longint entry_at(longint i);
    if (i < 0 || i >= TBL_DEPTH) return 0;
    return longint'(tbl[i]);
  endfunction

  function automatic longint halving_find(longint lo, longint hi, longint key);
    longint mid, v;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      v = entry_at(mid);
      if (v == key) return mid;
      if (v > key) hi = mid - 1;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  function automatic longint interp_find(longint n, longint key);
    longint lo, hi, alo, ahi, pos, v;
    lo = 0;
    hi = n - 1;
    while (lo <= hi && key >= entry_at(lo) && key <= entry_at(hi)) begin
      alo = entry_at(lo);
      ahi = entry_at(hi);
      if (lo == hi) return (alo == key) ? lo : -1;
      // With equal end values every entry between them matches the key.
      if (ahi == alo) return lo;
      pos = lo + ((key - alo) * (hi - lo)) / (ahi - alo);
      v = entry_at(pos);
      if (v == key) return pos;
      if (v < key) lo = pos + 1;
      else hi = pos - 1;
    end
    return -1;
  endfunction

  function automatic answer_t search_answer(longint key);
    longint n, b, top, hit;
    answer_t a;
    n = (count_q > TBL_DEPTH) ? TBL_DEPTH : longint'(count_q);
    hit = -1;
    if (n != 0) begin
      case (mode_q)
        MODE_LINEAR: begin
          for (longint i = 0; i < n && hit < 0; i++)
            if (entry_at(i) == key) hit = i;
        end
        MODE_BINARY: hit = halving_find(0, n - 1, key);
        MODE_INTERP: hit = interp_find(n, key);
        default: begin
          if (entry_at(0) == key) hit = 0;
          else begin
            b = 1;
            while (b < n && entry_at(b) <= key) b = b * 2;
            top = (b < n - 1) ? b : n - 1;
            hit = halving_find(b / 2, top, key);
          end
        end
      endcase
    end
    a.found    = (hit >= 0);
    a.position = (hit >= 0) ? hit[POS_W-1:0] : '0;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      mode_q        <= MODE_BINARY;
      count_q       <= '0;
      fail_count    <= 0;
      searches_seen <= 0;
      due_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODE) mode_q <= cfg_data[MODE_W-1:0];
        else count_q <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (in_action == ACT_WRITE) tbl[in_index] <= in_value;
        else begin
          due_answers.push_back(search_answer(longint'(in_value)));
          searches_seen <= searches_seen + 1;
        end
      end
      if (out_valid && !out_stall) begin
        got.found    = out_found;
        got.position = out_position;
        if (due_answers.size() == 0) begin
          $display("%0t: result beat with nothing expected: found %0d position %0d",
                   $time, got.found, got.position);
          errs++;
        end else begin
          want = due_answers.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found mismatch: expected %0d actual %0d",
                     $time, want.found, got.found);
            errs++;
          end
          if (got.position !== want.position) begin
            $display("%0t: position mismatch: expected %0d actual %0d",
                     $time, want.position, got.position);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

[tb/sv/sorted_table_search_top_test.sv]
// Test top for the sorted table search: drives load, search and register
// beats, stalls the result side and gives the verdict.
// Depends on sts_pkg, sorted_table_search_top and sts_search_checker.
module sorted_table_search_top_test;
  import sts_pkg::*;

  localparam int  TBL_DEPTH  = 1024;
  localparam int  IDLE_LIMIT = 200000;
  localparam longint VAL_MIN = -64'sd2147483648;
  localparam longint VAL_MAX = 64'sd2147483647;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid, in_stall, in_action;
  logic [INDEX_W-1:0]         in_index;
  logic signed [DATA_W-1:0]   in_value;
  logic                       out_valid, out_stall, out_found;
  logic [POS_W-1:0]           out_position;
  logic                       cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COUNT_W-1:0]         cfg_data;
  int                         fail_count, answers_waiting, searches_seen;
  int                         idle_cycles;
  int                         random_items;
  int                         phases;
  logic                       quiet;
  longint                     shadow [0:TBL_DEPTH-1];
  logic [COUNT_W-1:0]         cur_count;

  always #5 clk = ~clk;

  sorted_table_search_top dut (.*);

  sts_search_checker u_checker (.*);

  always @(posedge clk) out_stall <= !quiet && ($urandom_range(0, 99) < 9);

  // Watchdog: any accepted beat on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_beat(logic act, logic [INDEX_W-1:0] idx, longint v);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_index  <= idx;
    in_value  <= v[DATA_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_WRITE) shadow[idx] = v;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_waiting != 0) @(posedge clk);
    // A trailing load beat gives no result, so allow it to finish.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_COUNT) cur_count = data;
  endtask

  task automatic configure(logic [MODE_W-1:0] m, logic [COUNT_W-1:0] n);
    settle();
    write_reg(REG_MODE, m);
    write_reg(REG_COUNT, n);
    cfg_valid <= 1'b0;
  endtask

  function automatic longint pick_key();
    int n, r;
    longint k;
    n = (cur_count > TBL_DEPTH) ? TBL_DEPTH : cur_count;
    r = $urandom_range(0, 9);
    if (n == 0 && r < 7) r = 7;
    k = shadow[$urandom_range(0, n > 0 ? n - 1 : 0)];
    case (r)
      5: k = (k == VAL_MAX) ? k : k + 1;
      6: k = (k == VAL_MIN) ? k : k - 1;
      7: k = longint'($signed($urandom));
      8: k = VAL_MIN;
      9: k = VAL_MAX;
      default: ;
    endcase
    return k;
  endfunction

  // Rewrites one entry; usually within its neighbours so the order holds.
  task automatic rewrite_entry();
    int i;
    longint lo, hi, span;
    i  = $urandom_range(0, TBL_DEPTH - 1);
    lo = (i == 0) ? VAL_MIN : shadow[i-1];
    hi = (i == TBL_DEPTH - 1) ? VAL_MAX : shadow[i+1];
    if ($urandom_range(0, 9) == 0 || hi < lo) begin
      send_beat(ACT_WRITE, i[INDEX_W-1:0], longint'($signed($urandom)));
    end else begin
      span = hi - lo + 1;
      send_beat(ACT_WRITE, i[INDEX_W-1:0], lo + longint'({$urandom, $urandom} % span));
    end
  endtask

  initial begin
    longint v;
    int n_items, pick;
    logic [MODE_W-1:0] m;
    logic [COUNT_W-1:0] n;
    rst_n = 1'b0;
    in_valid  <= 1'b0;
    in_action <= ACT_WRITE;
    in_index  <= '0;
    in_value  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_data  <= '0;
    quiet = 1'b0;
    cur_count = '0;
    random_items = 0;
    phases = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table in ascending order so no unwritten entry is read.
    v = VAL_MIN;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (i == TBL_DEPTH - 1) v = VAL_MAX;
      else if (i > 0) v = v + $urandom_range(0, 8388607);
      if (v > VAL_MAX) v = VAL_MAX;
      send_beat(ACT_WRITE, i[INDEX_W-1:0], v);
    end

    // Empty table with the reset mode, then a count beyond the table.
    send_beat(ACT_SEARCH, '0, VAL_MIN);
    for (int mi = 0; mi < 4; mi++) begin
      m = mi[MODE_W-1:0];
      configure(m, (mi == 0) ? 11'd2047 : 11'd1024);
      send_beat(ACT_SEARCH, '1, VAL_MIN);
      send_beat(ACT_SEARCH, '0, VAL_MAX);
      send_beat(ACT_SEARCH, '0, shadow[517]);
      send_beat(ACT_SEARCH, '1, shadow[3] + 1);
    end
    configure(MODE_EXPO, 11'd0);
    send_beat(ACT_SEARCH, '0, 64'sd0);
    // Equal end values for interpolation: four entries all at the minimum.
    for (int i = 1; i < 4; i++) send_beat(ACT_WRITE, i[INDEX_W-1:0], VAL_MIN);
    configure(MODE_INTERP, 11'd4);
    send_beat(ACT_SEARCH, '0, VAL_MIN);
    configure(MODE_LINEAR, 11'd1);
    send_beat(ACT_SEARCH, '0, VAL_MIN);

    // Random phases: mostly small counts, a few at the extremes.
    while (random_items < 880) begin
      quiet = (phases >= 8 && phases < 12);
      m = MODE_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      case (pick)
        0: n = 11'd1024;
        1: n = $urandom_range(0, 2) == 0 ? 11'd2047 : 11'd0;
        2: n = COUNT_W'($urandom_range(1, 1023));
        default: n = COUNT_W'($urandom_range(1, 64));
      endcase
      configure(m, n);
      n_items = (n > 256 && m == MODE_LINEAR) ? 10 : 40;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < 15) rewrite_entry();
        else send_beat(ACT_SEARCH, INDEX_W'($urandom), pick_key());
        random_items++;
      end
      phases++;
    end
    quiet = 1'b0;
    settle();
    $display("Ran %0d random phases over all four search modes; %0d searches checked.",
             phases, searches_seen);
    if (fail_count == 0 && answers_waiting == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
